// ===== rtl/core/multi_voice_sample_mixer_with_fade_defines.svh =====
// Assertion macros shared by the mixer checker.
// No dependencies.
`ifndef MULTI_VOICE_SAMPLE_MIXER_WITH_FADE_DEFINES_SVH
`define MULTI_VOICE_SAMPLE_MIXER_WITH_FADE_DEFINES_SVH

// same-cycle implication
`define MVMIX_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mixer assertion failed");

// next-cycle implication
`define MVMIX_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mixer assertion failed");

`endif

// ===== rtl/core/mvmix_pkg.sv =====
// Shared types and constants for the multi-voice sample mixer.
// No dependencies.
`timescale 1ns / 1ps

package mvmix_pkg;

  localparam int DEF_VOICES           = 16;
  localparam int DEF_GAIN_SHIFT       = 8;
  localparam int DEF_SAMPLE_ADDR_BITS = 16;

  localparam logic [2:0] F_LOAD    = 3'd0;
  localparam logic [2:0] F_ONESHOT = 3'd1;
  localparam logic [2:0] F_PERSIST = 3'd2;
  localparam logic [2:0] F_TICK    = 3'd3;
  localparam logic [2:0] F_FADE    = 3'd4;
  localparam logic [2:0] F_MIX     = 3'd5;
  localparam logic [2:0] F_RESTART = 3'd6;

  localparam logic [8:0] GAIN_RESET = 9'd256;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] sample_value;
    logic [15:0]        mem_address;
    logic [15:0]        sound_base;
    logic [15:0]        sound_length;
    logic [8:0]         voice_gain;
    logic               loop_flag;
    logic               play_flag;
    logic               reset_flag;
    logic [15:0]        fade_period;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic               fade_done;
    logic               status;
  } res_t;

endpackage

// ===== rtl/core/mvmix_mul.sv =====
// Shared signed-by-unsigned multiplier with registered product.
// No dependencies.
`timescale 1ns / 1ps

module mvmix_mul #(
  parameter int AW = 21,
  parameter int BW = 9
) (
  input  logic                   clk,
  input  logic signed [AW-1:0]   a,
  input  logic [BW-1:0]          b,
  output logic signed [AW+BW:0]  p
);

  always_ff @(posedge clk) begin
    p <= (AW+BW+1)'(a * $signed({1'b0, b}));
  end

endmodule

// ===== rtl/core/multi_voice_sample_mixer_with_fade.sv =====
// Multi-voice sample mixer top level: sample memory, voice table, sequencer.
// Depends on mvmix_pkg and mvmix_mul.
//
//   channel  | direction | handshake        | word
//   cmd      | in        | cmd_valid/stall  | mvmix_pkg::cmd_t
//   rsp      | out       | rsp_valid/stall  | mvmix_pkg::res_t
//   apb      | in        | psel/penable     | music_gain @0, effects_gain @4
//
// Sequence from accept to next accept, result not stalled:
// Load, fade control, restart, zero-length one-shot and unused codes: straight to the result.
// One-shot start, persistent update, end tick: a walk over all VOICES (one voice per cycle).
// Mix: voice walk, a pipeline drain, then the shared multiplier for music and effects.
// Synchronous reset clears voices and fade; sample memory is not cleared.
// A stalled result is held while the next word is taken.
`timescale 1ns / 1ps

module multi_voice_sample_mixer_with_fade #(
  parameter int VOICES           = mvmix_pkg::DEF_VOICES,
  parameter int GAIN_SHIFT       = mvmix_pkg::DEF_GAIN_SHIFT,
  parameter int SAMPLE_ADDR_BITS = mvmix_pkg::DEF_SAMPLE_ADDR_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  mvmix_pkg::cmd_t   cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output mvmix_pkg::res_t   rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int VIW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW    = $clog2(VOICES + 1);
  localparam int MAXG  = 1 << GAIN_SHIFT;
  localparam int GW    = (GAIN_SHIFT + 1 > 9) ? GAIN_SHIFT + 1 : 9;
  localparam int AW    = 17 + $clog2(VOICES);
  localparam int PW    = AW + GW + 1;
  localparam int DEPTH = 1 << SAMPLE_ADDR_BITS;

  localparam logic signed [AW:0] SAT_HI = (AW+1)'(32767);
  localparam logic signed [AW:0] SAT_LO = -(AW+1)'(32768);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WALK  = 8'b0000_0010,
    S_DRAIN = 8'b0000_0100,
    S_MUS1  = 8'b0000_1000,
    S_MUS2  = 8'b0001_0000,
    S_MUS3  = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [15:0]   base;
    logic [15:0]   len;
    logic [15:0]   pos;
    logic [GW-1:0] vol;
    logic          loop;
    logic          persist;
    logic          paused;
    logic          finished;
    logic          touched;
  } voice_t;

  function automatic logic [GW-1:0] clamp_gain(input logic [8:0] g);
    logic [GW-1:0] gx;
    gx = GW'(g);
    return (gx > GW'(MAXG)) ? GW'(MAXG) : gx;
  endfunction

  state_t           st;
  logic             start_pending;
  mvmix_pkg::cmd_t  cq;
  mvmix_pkg::res_t  res_q;
  logic [CW-1:0]    idx;
  logic [VOICES-1:0] active;
  voice_t           vrec [VOICES];
  logic             ff_found;
  logic [VIW-1:0]   ff_idx;
  logic             kept;
  logic [8:0]       music_gain;
  logic [8:0]       effects_gain;
  logic [GW-1:0]    fade_level;
  logic [15:0]      fade_period;
  logic [15:0]      fade_countdown;

  logic [15:0]      mem [DEPTH];
  logic [15:0]      rdata;
  logic             p1;
  logic             p2;
  logic [GW-1:0]    vol1;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] music_r;

  logic signed [AW-1:0] mul_a;
  logic [GW-1:0]        mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;
  logic signed [AW-1:0] prod_t;

  logic [VIW-1:0]   v;
  voice_t           cur;
  voice_t           nrec;
  logic             nact;
  logic             vwe;
  logic             rd_en;
  logic [SAMPLE_ADDR_BITS-1:0] rd_addr;
  logic             match;
  logic [16:0]      pos_inc;
  logic             accept;
  logic             last_voice;
  logic signed [AW:0] sum;
  logic signed [15:0] sat;
  voice_t           new_rec;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = (st != S_IDLE);
  assign pready    = 1'b1;
  assign prdata    = paddr[2] ? 32'(effects_gain) : 32'(music_gain);
  assign last_voice = (idx == CW'(VOICES - 1));

  assign prod_sh = prod >>> GAIN_SHIFT;
  assign prod_t  = prod_sh[AW-1:0];

  mvmix_mul #(.AW(AW), .BW(GW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  always_comb begin
    unique case (st)
      S_MUS1: begin
        mul_a = AW'(cq.sample_value);
        mul_b = clamp_gain(music_gain);
      end
      S_MUS2: begin
        mul_a = prod_t;
        mul_b = fade_level;
      end
      S_MUS3: begin
        mul_a = acc;
        mul_b = clamp_gain(effects_gain);
      end
      default: begin
        mul_a = AW'($signed(rdata));
        mul_b = vol1;
      end
    endcase
  end

  // voice walk, one voice per cycle
  always_comb begin
    v       = idx[VIW-1:0];
    cur     = vrec[v];
    nrec    = cur;
    nact    = active[v];
    vwe     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = SAMPLE_ADDR_BITS'({1'b0, cur.base} + {1'b0, cur.pos});
    match   = active[v] && cur.persist && (cur.base == cq.sound_base);
    pos_inc = {1'b0, cur.pos} + 17'd1;
    if (st == S_WALK) begin
      case (cq.func)
        mvmix_pkg::F_MIX: begin
          if (active[v] && !cur.paused && !cur.finished) begin
            rd_en = 1'b1;
            vwe   = 1'b1;
            if (pos_inc >= {1'b0, cur.len}) begin
              if (cur.loop) nrec.pos = '0;
              else if (cur.persist) begin
                nrec.pos      = pos_inc[15:0];
                nrec.finished = 1'b1;
              end else nact = 1'b0;
            end else begin
              nrec.pos = pos_inc[15:0];
            end
          end
        end
        mvmix_pkg::F_PERSIST: begin
          if (match) begin
            vwe = 1'b1;
            if (cq.reset_flag) nact = 1'b0;
            else begin
              nrec.vol     = clamp_gain(cq.voice_gain);
              nrec.touched = 1'b1;
              nrec.paused  = !cq.play_flag;
            end
          end
        end
        mvmix_pkg::F_TICK: begin
          if (active[v] && cur.persist) begin
            vwe = 1'b1;
            if (cur.touched) nrec.touched = 1'b0;
            else nact = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    new_rec          = '0;
    new_rec.base     = cq.sound_base;
    new_rec.len      = cq.sound_length;
    new_rec.vol      = clamp_gain(cq.voice_gain);
    new_rec.persist  = (cq.func == mvmix_pkg::F_PERSIST);
    new_rec.touched  = (cq.func == mvmix_pkg::F_PERSIST);
    new_rec.loop     = (cq.func == mvmix_pkg::F_PERSIST) && cq.loop_flag;
  end

  always_comb begin
    sum = $signed({music_r[AW-1], music_r}) + $signed({prod_t[AW-1], prod_t});
    if (sum > SAT_HI) sat = 16'sd32767;
    else if (sum < SAT_LO) sat = -16'sd32768;
    else sat = sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (accept && cmd.func == mvmix_pkg::F_LOAD) begin
      mem[SAMPLE_ADDR_BITS'(cmd.mem_address)] <= cmd.sample_value;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vwe) vrec[v] <= nrec;
    if (st == S_FIN && start_pending && ff_found) vrec[ff_idx] <= new_rec;
    if (accept) cq <= cmd;
    vol1 <= cur.vol;
    if (st == S_MUS3) music_r <= prod_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_IDLE;
      start_pending  <= 1'b0;
      idx            <= '0;
      active         <= '0;
      ff_found       <= 1'b0;
      ff_idx         <= '0;
      kept           <= 1'b0;
      music_gain     <= mvmix_pkg::GAIN_RESET;
      effects_gain   <= mvmix_pkg::GAIN_RESET;
      fade_level     <= '0;
      fade_period    <= '0;
      fade_countdown <= '0;
      p1             <= 1'b0;
      p2             <= 1'b0;
      acc            <= '0;
      res_q          <= '0;
      rsp_valid      <= 1'b0;
      rsp            <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2]) effects_gain <= pwdata[8:0];
        else music_gain <= pwdata[8:0];
      end
      if (rsp_valid && !rsp_stall && st != S_FIN) rsp_valid <= 1'b0;
      if (vwe) active[v] <= nact;
      p1 <= rd_en;
      p2 <= p1;
      if (p2) acc <= acc + prod_t;

      unique case (st)
        S_IDLE: begin
          if (accept) begin
            idx           <= '0;
            ff_found      <= 1'b0;
            kept          <= 1'b0;
            acc           <= '0;
            res_q         <= '0;
            start_pending <= 1'b0;
            st            <= S_FIN;
            case (cmd.func)
              mvmix_pkg::F_FADE: begin
                fade_period    <= cmd.fade_period;
                fade_countdown <= cmd.fade_period;
              end
              mvmix_pkg::F_RESTART: begin
                fade_level     <= GW'(MAXG);
                fade_period    <= '0;
                fade_countdown <= '0;
              end
              mvmix_pkg::F_ONESHOT: begin
                if (cmd.sound_length != '0) st <= S_WALK;
              end
              mvmix_pkg::F_PERSIST, mvmix_pkg::F_TICK, mvmix_pkg::F_MIX: begin
                st <= S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (!ff_found && !nact) begin
            ff_found <= 1'b1;
            ff_idx   <= v;
          end
          if (match && !cq.reset_flag) kept <= 1'b1;
          idx <= idx + CW'(1);
          if (last_voice) begin
            if (cq.func == mvmix_pkg::F_MIX) st <= S_DRAIN;
            else st <= S_SUM;
          end
        end
        S_DRAIN: begin
          if (!p1 && !p2) st <= S_MUS1;
        end
        S_MUS1: st <= S_MUS2;
        S_MUS2: st <= S_MUS3;
        S_MUS3: st <= S_SUM;
        S_SUM: begin
          st <= S_FIN;
          if (cq.func == mvmix_pkg::F_MIX) begin
            res_q.mixed_sample <= sat;
            if (fade_period != '0 && fade_level != '0) begin
              if (fade_countdown <= 16'd1) begin
                fade_countdown  <= fade_period;
                fade_level      <= fade_level - GW'(1);
                res_q.fade_done <= (fade_level == GW'(1));
              end else begin
                fade_countdown <= fade_countdown - 16'd1;
              end
            end
          end else if (cq.func == mvmix_pkg::F_ONESHOT ||
                       (cq.func == mvmix_pkg::F_PERSIST && !kept &&
                        cq.play_flag && cq.sound_length != '0)) begin
            start_pending <= 1'b1;
            res_q.status  <= !ff_found;
          end
        end
        S_FIN: begin
          if (start_pending && ff_found) active[ff_idx] <= 1'b1;
          start_pending <= 1'b0;
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            rsp       <= res_q;
            st        <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/mvmix_chk.sv =====
// Port-level checker for the mixer, bound to the top level.
// Depends on mvmix_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "multi_voice_sample_mixer_with_fade_defines.svh"

module mvmix_chk (
  input logic            clk,
  input logic            rst,
  input logic            cmd_valid,
  input logic            cmd_stall,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input mvmix_pkg::res_t rsp
);

  `MVMIX_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid)
  `MVMIX_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall)
  `MVMIX_ASSERT_NOW(a_done_no_status, clk, rst, rsp_valid && rsp.fade_done, !rsp.status)
  `MVMIX_ASSERT_NOW(a_sample_no_status, clk, rst, rsp_valid && rsp.mixed_sample != 16'sd0, !rsp.status)

endmodule

bind multi_voice_sample_mixer_with_fade mvmix_chk u_mvmix_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd_valid),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
